>>> src/rau_pkg.sv
// shared constants, codes and types for the rational arithmetic unit
`default_nettype none
package rau_pkg;
  localparam int WIDTH = 32;
  localparam int NW = 64;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_POW = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_OVF    = 2'd1;
  localparam logic [1:0] ST_DIV0   = 2'd2;
  localparam logic [1:0] ST_NEGEXP = 2'd3;

  localparam logic [NW-1:0] DLIM = (64'd1 << (WIDTH - 1)) - 64'd1;
  localparam logic [NW-1:0] PLIM = 64'd1 << (WIDTH - 1);

  typedef struct packed {
    logic          start;
    logic [NW-1:0] x;
    logic [NW-1:0] y;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [NW-1:0] quo;
    logic [NW-1:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

>>> src/rau_divider.sv
// radix-2 restoring divider for 64-bit unsigned operands, one bit per cycle
`default_nettype none
module rau_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rau_pkg::div_req_t req,
  output rau_pkg::div_rsp_t      rsp
);
  logic [rau_pkg::NW-1:0] q_r, q_nxt, r_r, r_nxt, d_r;
  logic [6:0]             cnt_r;
  logic                   busy_r, done_r;
  logic [rau_pkg::NW:0]   trial;
  logic [rau_pkg::NW:0]   diff;

  always_comb begin
    trial = {r_r, q_r[rau_pkg::NW-1]};
    diff  = trial - {1'b0, d_r};
    if (!diff[rau_pkg::NW]) begin
      r_nxt = diff[rau_pkg::NW-1:0];
      q_nxt = {q_r[rau_pkg::NW-2:0], 1'b1};
    end else begin
      r_nxt = trial[rau_pkg::NW-1:0];
      q_nxt = {q_r[rau_pkg::NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'(rau_pkg::NW);
        q_r    <= req.x;
        r_r    <= '0;
        d_r    <= req.y;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        r_r   <= r_nxt;
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
  assign rsp.rem  = r_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> $past(busy_r)) else $error("divider done without busy");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("divider restarted while busy");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != 7'd0)) else $error("divider count underflow");
endmodule
`default_nettype wire

>>> src/rational_arithmetic_unit_top.sv
// top level: sequencer, 33x33 multiplier and shared divider for rational operations
//
//  channel | dir | handshake          | payload
//  in_     | in  | tvalid/tready      | tdata: a_num, a_den, b_num, b_den; tuser: func
//  out_    | out | tvalid/tready      | tdata: r_num, r_den; tuser: status
//
// every divider pass runs start, 64 quotient steps, then done;
// an item takes one divider pass per euclid remainder step plus two reducing
// divides and the setup states, so the remainder count sets its length
// power reduces its base the same way first, then goes through S_POW and
// S_CHK per exponent step, at most about 32 steps before it finishes or overflows
// rst_n clears the sequencer; in_tready is high only in idle
// a held result stalls the sequencer in its output state until out_tready
`default_nettype none
module rational_arithmetic_unit_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // a_num[31:0], a_den[62:32], b_num[94:63],
                                        // b_den[125:95], zero[127:126]
  input  wire logic [2:0]   in_tuser,   // func
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,  // r_num[31:0], r_den[62:32], zero[63]
  output logic [1:0]        out_tuser   // status
);
  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL1  = 4'd1;
  localparam logic [3:0] S_MUL2  = 4'd2;
  localparam logic [3:0] S_GCD   = 4'd3;
  localparam logic [3:0] S_GCDW  = 4'd4;
  localparam logic [3:0] S_DIVN  = 4'd5;
  localparam logic [3:0] S_DIVNW = 4'd6;
  localparam logic [3:0] S_DIVD  = 4'd7;
  localparam logic [3:0] S_DIVDW = 4'd8;
  localparam logic [3:0] S_POW   = 4'd9;
  localparam logic [3:0] S_CHK   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_MUL3  = 4'd12;

  logic [3:0]  st_r;
  logic [2:0]  func_r;
  logic [31:0] an_r, bn_r;
  logic [30:0] ad_r, bd_r;
  logic [63:0] x_r, y_r;      // gcd working pair
  logic [63:0] n_r, d_r;      // fraction magnitude
  logic [63:0] bn_m_r, bd_m_r; // power base
  logic [31:0] exp_r;
  logic        neg_r, pow_r, gpow_r;
  logic [63:0] s_r;           // first cross product
  logic [31:0] rn_r;
  logic [30:0] rd_r;
  logic [1:0]  rs_r;

  // single 33x33 signed multiplier, operands picked by state
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  assign mp = ma * mb;

  rau_pkg::div_req_t dreq;
  rau_pkg::div_rsp_t drsp;
  rau_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [2:0]  i_func;
  logic [31:0] i_an, i_bn;
  logic [30:0] i_ad, i_bd;
  assign i_func = in_tuser;
  assign i_an   = in_tdata[31:0];
  assign i_ad   = in_tdata[62:32];
  assign i_bn   = in_tdata[94:63];
  assign i_bd   = in_tdata[125:95];

  logic [63:0] mag_an;
  assign mag_an = an_r[31] ? 64'(-{{32{an_r[31]}}, an_r}) : {32'd0, an_r};

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_r)
      S_MUL1: begin
        ma = {an_r[31], an_r};
        mb = (func_r == rau_pkg::OP_MUL) ? {bn_r[31], bn_r} : {2'b00, bd_r};
      end
      S_MUL2: begin
        if (func_r == rau_pkg::OP_DIV) begin
          ma = {2'b00, ad_r};
          mb = bn_r[31] ? 33'(-{1'b1, bn_r}) : {1'b0, bn_r};
        end else if (func_r == rau_pkg::OP_MUL) begin
          ma = {2'b00, ad_r};
          mb = {2'b00, bd_r};
        end else begin
          ma = {bn_r[31], bn_r};
          mb = {2'b00, ad_r};
        end
      end
      S_MUL3: begin
        // common denominator for add and subtract
        ma = {2'b00, ad_r};
        mb = {2'b00, bd_r};
      end
      S_POW: begin
        ma = {1'b0, n_r[31:0]};
        mb = {1'b0, bn_m_r[31:0]};
      end
      S_CHK: begin
        ma = {1'b0, d_r[31:0]};
        mb = {1'b0, bd_m_r[31:0]};
      end
      default: ;
    endcase
  end

  logic [63:0] sum;
  logic signed [63:0] sx, sy;
  always_comb begin
    sx = s_r;
    sy = mp[63:0];
    sum = (func_r == rau_pkg::OP_ADD) ? 64'(sx + sy) : 64'(sx - sy);
  end

  always_ff @(posedge clk) begin
    dreq.start <= rst_n && ((st_r == S_GCD && y_r != '0) ||
                            st_r == S_DIVN || st_r == S_DIVD);
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: if (in_tvalid) begin
          func_r <= i_func; an_r <= i_an; ad_r <= i_ad; bn_r <= i_bn; bd_r <= i_bd;
          rd_r <= 31'd1;
          if (i_func > rau_pkg::OP_POW) begin
            rn_r <= '0; rs_r <= rau_pkg::ST_OK; st_r <= S_OUT;
          end else if (i_ad == '0 || (i_func != rau_pkg::OP_POW && i_bd == '0) ||
                       (i_func == rau_pkg::OP_DIV && i_bn == '0)) begin
            rn_r <= '0; rs_r <= rau_pkg::ST_DIV0; st_r <= S_OUT;
          end else if (i_func == rau_pkg::OP_POW) begin
            if (i_bn[31]) begin
              rn_r <= '0; rs_r <= rau_pkg::ST_NEGEXP; st_r <= S_OUT;
            end else if (i_bn == '0) begin
              rn_r <= 32'd1; rs_r <= rau_pkg::ST_OK; st_r <= S_OUT;
            end else if (i_an == '0) begin
              rn_r <= '0; rs_r <= rau_pkg::ST_OK; st_r <= S_OUT;
            end else begin
              pow_r <= 1'b1; gpow_r <= 1'b1; st_r <= S_POW;
              exp_r <= i_bn;
              neg_r <= i_an[31] & i_bn[0];
            end
          end else begin
            pow_r <= 1'b0; gpow_r <= 1'b0;
            st_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          s_r <= mp[63:0];
          if (func_r == rau_pkg::OP_MUL || func_r == rau_pkg::OP_DIV) begin
            neg_r <= mp[65] ^ ((func_r == rau_pkg::OP_DIV) & bn_r[31]);
            n_r   <= mp[65] ? 64'(-mp[63:0]) : mp[63:0];
          end
          st_r <= S_MUL2;
        end
        S_MUL2: begin
          if (func_r == rau_pkg::OP_ADD || func_r == rau_pkg::OP_SUB) begin
            neg_r <= sum[63];
            n_r   <= sum[63] ? 64'(-sum) : sum;
            st_r  <= S_MUL3;
          end else begin
            d_r  <= mp[63:0];
            st_r <= S_CHK;
          end
        end
        S_MUL3: begin
          d_r  <= mp[63:0];
          st_r <= S_CHK;
        end
        S_POW: begin
          // first pass sets up gcd of base; afterwards multiplies
          if (gpow_r) begin
            x_r <= mag_an; y_r <= {33'd0, ad_r};
            st_r <= S_GCD;
          end else begin
            n_r <= mp[63:0];
            st_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (pow_r) begin
            // n_r holds the new numerator; d_r times base denominator here
            if (n_r > rau_pkg::PLIM || mp[63:0] > rau_pkg::PLIM) begin
              rn_r <= '0; rd_r <= 31'd1; rs_r <= rau_pkg::ST_OVF; st_r <= S_OUT;
            end else begin
              d_r   <= mp[63:0];
              exp_r <= exp_r - 32'd1;
              if (exp_r == 32'd1) begin
                pow_r <= 1'b0; st_r <= S_CHK;
              end else begin
                st_r <= S_POW;
              end
            end
          end else if (n_r == '0) begin
            rn_r <= '0; rd_r <= 31'd1; rs_r <= rau_pkg::ST_OK; st_r <= S_OUT;
          end else begin
            x_r <= n_r; y_r <= d_r; st_r <= S_GCD;
          end
        end
        S_GCD: begin
          if (y_r == '0) begin
            if (gpow_r) begin
              // reduce base by gcd through the divider
              st_r <= S_DIVN;
            end else begin
              st_r <= S_DIVN;
            end
          end else begin
            dreq.x <= x_r; dreq.y <= y_r; st_r <= S_GCDW;
          end
        end
        S_GCDW: if (drsp.done) begin
          x_r <= y_r; y_r <= drsp.rem; st_r <= S_GCD;
        end
        S_DIVN: begin
          dreq.x <= gpow_r ? mag_an : n_r; dreq.y <= x_r;
          st_r <= S_DIVNW;
        end
        S_DIVNW: if (drsp.done) begin
          n_r <= drsp.quo; st_r <= S_DIVD;
        end
        S_DIVD: begin
          dreq.x <= gpow_r ? {33'd0, ad_r} : d_r; dreq.y <= x_r;
          st_r <= S_DIVDW;
        end
        S_DIVDW: if (drsp.done) begin
          if (gpow_r) begin
            gpow_r <= 1'b0;
            bn_m_r <= n_r; bd_m_r <= drsp.quo;
            if (n_r == 64'd1 && drsp.quo == 64'd1) begin
              rn_r <= neg_r ? '1 : 32'd1; rd_r <= 31'd1; rs_r <= rau_pkg::ST_OK;
              st_r <= S_OUT;
            end else begin
              n_r <= 64'd1; d_r <= 64'd1; st_r <= S_POW;
            end
          end else if (n_r > (neg_r ? rau_pkg::PLIM : rau_pkg::DLIM) ||
                       drsp.quo > rau_pkg::DLIM) begin
            rn_r <= '0; rd_r <= 31'd1; rs_r <= rau_pkg::ST_OVF; st_r <= S_OUT;
          end else begin
            rn_r <= neg_r ? 32'(-n_r[31:0]) : n_r[31:0];
            rd_r <= drsp.quo[30:0];
            rs_r <= rau_pkg::ST_OK;
            st_r <= S_OUT;
          end
        end
        S_OUT: if (out_tready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = {1'b0, rd_r, rn_r};
  assign out_tuser  = rs_r;

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready and valid together");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != rau_pkg::ST_OK) |-> (rn_r == '0 && rd_r == 31'd1))
    else $error("error result not 0/1");
  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (rd_r != '0)) else $error("zero denominator out");
endmodule
`default_nettype wire
